/* design/gcr_pkg.sv */
// shared types and constants for the gamma color ramp
`default_nettype none
package gcr_pkg;

  localparam int THICK_W = 8;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_INNER_COLOR = 2'd0;
  localparam cfg_idx_t CFG_OUTER_COLOR = 2'd1;
  localparam cfg_idx_t CFG_THICKNESS   = 2'd2;
  localparam cfg_idx_t CFG_GAMMA_MODE  = 2'd3;

endpackage
`default_nettype wire

/* design/gamma_color_ramp.sv */
// gamma color ramp top level: pipelined blend of inner and outer rgba colors
`default_nettype none
// Takes one layer beat per clock while in_stall is low and returns one rgba beat per
// layer, in order, after stages a, b and c, the divider and the square root.
// Each channel is weighted by multipliers, divided by thickness-1 in a restoring
// divider of 2*CHANNEL_BITS stages (one quotient bit per stage) and, in gamma mode,
// passed through a square root of CHANNEL_BITS stages (one root bit per stage).
// A stall on the result side freezes the whole pipeline and is passed to in_stall.
// cfg_ready is always high; registers should only be written while no beat is in flight.
module gamma_color_ramp #(
  parameter int CHANNEL_BITS = 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire gcr_pkg::cfg_idx_t               cfg_index,
  input  wire [4*CHANNEL_BITS-1:0]             cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [gcr_pkg::THICK_W-1:0]           in_layer,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [CHANNEL_BITS-1:0]              out_red,
  output logic [CHANNEL_BITS-1:0]              out_green,
  output logic [CHANNEL_BITS-1:0]              out_blue,
  output logic [CHANNEL_BITS-1:0]              out_alpha
);

  localparam int C  = CHANNEL_BITS;
  localparam int TW = gcr_pkg::THICK_W;
  localparam int CW = 4 * C;
  localparam int QW = 2 * C;
  localparam int NW = QW + TW;

  // configuration
  logic [CW-1:0] inner_r;
  logic [CW-1:0] outer_r;
  logic [TW-1:0] thick_r;
  logic          gamma_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '1;
      outer_r <= CW'(255);
      thick_r <= TW'(1);
      gamma_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gcr_pkg::CFG_INNER_COLOR: inner_r <= cfg_data;
        gcr_pkg::CFG_OUTER_COLOR: outer_r <= cfg_data;
        gcr_pkg::CFG_THICKNESS:   thick_r <= cfg_data[TW-1:0];
        gcr_pkg::CFG_GAMMA_MODE:  gamma_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage a: weights and divisor
  logic          va_r;
  logic [TW-1:0] wi_a_r, wo_a_r, d_a_r;
  logic          g_a_r;
  logic [TW-1:0] k_clamp;
  logic          thin;
  logic [TW-1:0] wi_nxt, wo_nxt, d_nxt;

  always_comb begin
    thin = (thick_r <= TW'(1));
    if (in_layer == '0)        k_clamp = TW'(1);
    else if (in_layer > thick_r) k_clamp = thick_r;
    else                       k_clamp = in_layer;
    wi_nxt = thin ? TW'(1) : thick_r - k_clamp;
    wo_nxt = thin ? '0     : k_clamp - TW'(1);
    d_nxt  = thin ? TW'(1) : thick_r - TW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wi_a_r <= wi_nxt;
      wo_a_r <= wo_nxt;
      d_a_r  <= d_nxt;
      g_a_r  <= gamma_r;
    end
  end

  // stage b: channel or squared channel
  logic          vb_r;
  logic [QW-1:0] a1_b_r [0:3];
  logic [QW-1:0] a2_b_r [0:3];
  logic [TW-1:0] wi_b_r, wo_b_r, d_b_r;
  logic          g_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wi_b_r <= wi_a_r;
      wo_b_r <= wo_a_r;
      d_b_r  <= d_a_r;
      g_b_r  <= g_a_r;
    end
  end

  for (genvar ch = 0; ch < 4; ch++) begin : g_sq
    logic [C-1:0] c1, c2;
    assign c1 = inner_r[(3-ch)*C +: C];
    assign c2 = outer_r[(3-ch)*C +: C];
    always_ff @(posedge clk) begin
      if (adv) begin
        a1_b_r[ch] <= g_a_r ? QW'(c1) * QW'(c1) : QW'(c1);
        a2_b_r[ch] <= g_a_r ? QW'(c2) * QW'(c2) : QW'(c2);
      end
    end
  end

  // stage c: weighted terms
  logic          vc_r;
  logic [NW-1:0] p1_c_r [0:3];
  logic [NW-1:0] p2_c_r [0:3];
  logic [TW-1:0] d_c_r;
  logic          g_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_c_r <= d_b_r;
      g_c_r <= g_b_r;
    end
  end

  for (genvar ch = 0; ch < 4; ch++) begin : g_mul
    always_ff @(posedge clk) begin
      if (adv) begin
        p1_c_r[ch] <= NW'(wi_b_r) * NW'(a1_b_r[ch]);
        p2_c_r[ch] <= NW'(wo_b_r) * NW'(a2_b_r[ch]);
      end
    end
  end

  // divider: index 0 holds the sum, each later stage resolves one quotient bit
  logic          dv_r    [0:QW];
  logic [TW-1:0] drem_r  [0:QW][0:3];
  logic [QW-1:0] dword_r [0:QW][0:3];
  logic [TW-1:0] dd_r    [0:QW];
  logic          dg_r    [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (adv) dv_r[0] <= vc_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_r[0] <= d_c_r;
      dg_r[0] <= g_c_r;
    end
  end

  for (genvar ch = 0; ch < 4; ch++) begin : g_sum
    logic [NW-1:0] sum;
    assign sum = p1_c_r[ch] + p2_c_r[ch];
    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[0][ch]  <= sum[NW-1:QW];
        dword_r[0][ch] <= sum[QW-1:0];
      end
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s] <= 1'b0;
      else if (adv) dv_r[s] <= dv_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dd_r[s] <= dd_r[s-1];
        dg_r[s] <= dg_r[s-1];
      end
    end
    for (genvar ch = 0; ch < 4; ch++) begin : g_ch
      logic [TW:0] r9, diff;
      logic        ge;
      assign r9   = {drem_r[s-1][ch], dword_r[s-1][ch][QW-1]};
      assign ge   = (r9 >= {1'b0, dd_r[s-1]});
      assign diff = r9 - {1'b0, dd_r[s-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[s][ch]  <= ge ? diff[TW-1:0] : r9[TW-1:0];
          dword_r[s][ch] <= {dword_r[s-1][ch][QW-2:0], ge};
        end
      end
    end
  end

  // square root: one root bit per stage, linear quotient carried alongside
  logic          sv_r    [1:C];
  logic          sg_r    [1:C];
  logic [C+1:0]  srem_r  [1:C][0:3];
  logic [QW-1:0] sx_r    [1:C][0:3];
  logic [C-1:0]  sroot_r [1:C][0:3];
  logic [C-1:0]  slin_r  [1:C][0:3];

  for (genvar s = 1; s <= C; s++) begin : g_sqrt
    logic vin, gin;
    if (s == 1) begin : g_src0
      assign vin = dv_r[QW];
      assign gin = dg_r[QW];
    end else begin : g_srcn
      assign vin = sv_r[s-1];
      assign gin = sg_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[s] <= 1'b0;
      else if (adv) sv_r[s] <= vin;
    end
    always_ff @(posedge clk) begin
      if (adv) sg_r[s] <= gin;
    end
    for (genvar ch = 0; ch < 4; ch++) begin : g_ch
      logic [C+1:0]  rin, rr, trial, rdiff;
      logic [QW-1:0] xin;
      logic [C-1:0]  rootin, linin;
      logic          ge;
      if (s == 1) begin : g_first
        assign rin    = '0;
        assign xin    = dword_r[QW][ch];
        assign rootin = '0;
        assign linin  = dword_r[QW][ch][C-1:0];
      end else begin : g_next
        assign rin    = srem_r[s-1][ch];
        assign xin    = sx_r[s-1][ch];
        assign rootin = sroot_r[s-1][ch];
        assign linin  = slin_r[s-1][ch];
      end
      assign rr    = {rin[C-1:0], xin[QW-1 -: 2]};
      assign trial = {rootin, 2'b01};
      assign ge    = (rr >= trial);
      assign rdiff = rr - trial;
      always_ff @(posedge clk) begin
        if (adv) begin
          srem_r[s][ch]  <= ge ? rdiff : rr;
          sx_r[s][ch]    <= {xin[QW-3:0], 2'b00};
          sroot_r[s][ch] <= {rootin[C-2:0], ge};
          slin_r[s][ch]  <= linin;
        end
      end
    end
  end

  assign out_valid = sv_r[C];
  assign out_red   = sg_r[C] ? sroot_r[C][0] : slin_r[C][0];
  assign out_green = sg_r[C] ? sroot_r[C][1] : slin_r[C][1];
  assign out_blue  = sg_r[C] ? sroot_r[C][2] : slin_r[C][2];
  assign out_alpha = sg_r[C] ? sroot_r[C][3] : slin_r[C][3];

  // divider remainder always stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[QW] |-> (drem_r[QW][0] < dd_r[QW]))
    else $error("divider remainder not below divisor");

  // thin line gives back the inner color
  a_thin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && thick_r <= TW'(1)) |->
      (out_red == inner_r[CW-1 -: C] && out_alpha == inner_r[C-1:0]))
    else $error("thin line result differs from inner color");

  // a stalled result freezes the whole pipeline
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(dv_r[QW]) && $stable(dword_r[QW][0])))
    else $error("pipeline moved under stall");

endmodule
`default_nettype wire
